[rtl/minmax_contrast_stretch_top_assert.svh]
// Assertion macros for the contrast stretch block.
// The clock and reset are taken from the module that uses the macros.
`ifndef MINMAX_CONTRAST_STRETCH_TOP_ASSERT_SVH
`define MINMAX_CONTRAST_STRETCH_TOP_ASSERT_SVH

// Holds at every clock edge outside reset.
`define MCS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define MCS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[rtl/mcs_pkg.sv]
`default_nettype none

package mcs_pkg;

	localparam int MaxPixels = 65536;
	localparam int AddrW     = $clog2(MaxPixels);
	localparam int CntW      = $clog2(MaxPixels + 1);
	localparam int SampleW   = 16;
	localparam int OutW      = 8;
	localparam int NumW      = SampleW + OutW;

	typedef logic [SampleW-1:0] sample_t;
	typedef logic [OutW-1:0]    pix8_t;

	typedef struct packed {
		sample_t c;
		sample_t b;
		sample_t a;
	} pixel_t;

	// channel select codes
	localparam logic [1:0] CH_A = 2'd0;
	localparam logic [1:0] CH_B = 2'd1;
	localparam logic [1:0] CH_C = 2'd2;

	// input function codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_READ = 1'b1;

endpackage

`default_nettype wire

[rtl/minmax_contrast_stretch_top.sv]
`default_nettype none
// Min/max contrast stretch, 16-bit samples to 8-bit pixels.
// Input channel (in_valid / in_stall, fields func, sample_a..c): a load transaction
// (func 0) stores one pixel into the frame memory and updates the shared running
// min/max. A readout transaction (func 1) returns the next
// stored pixel, channel a (RGB: a..c) mapped to floor((s - min) * 255 / range), others 0.
// Output channel (out_valid / out_stall): one transaction per readout, none per load.
// last_pixel marks the end of the frame; frame_empty marks a readout with no pixels.
// Config channel (cfg_valid / cfg_ready, cfg_data): color_mode, 0 grey, 1 RGB.
// Sequence: a readout runs through the memory read step, then per channel one setup
// step and the steps of the shared restoring divider (saturation check plus
// eight quotient bits; a saturating channel stops after the check), then a final
// step that hands the result to the output register. An empty readout goes
// straight to the final step. The next transaction can be accepted in the cycle
// in which out_valid rises. in_stall is high for the whole readout. The output
// register lets the next item enter while a result waits; if the receiver stalls,
// a finished readout waits in its final step until the output register frees up.
// Reset clears the frame (no pixels, min 65535, max 0) and color_mode; the frame
// memory itself is not cleared and needs no clearing pass.
`include "minmax_contrast_stretch_top_assert.svh"

module minmax_contrast_stretch_top
	import mcs_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic         func,
	input  wire logic [15:0]  sample_a,
	input  wire logic [15:0]  sample_b,
	input  wire logic [15:0]  sample_c,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [7:0]        out_a,
	output logic [7:0]        out_b,
	output logic [7:0]        out_c,
	output logic              last_pixel,
	output logic              frame_empty,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic         cfg_data
);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;  // memory read in flight
	localparam logic [2:0] ST_PREP = 3'd2;  // set up dividend for one channel
	localparam logic [2:0] ST_DIV  = 3'd3;  // one quotient step per cycle
	localparam logic [2:0] ST_FIN  = 3'd4;  // hand result to output register

	localparam logic [3:0] StepTop = 4'(OutW);

	logic [2:0]      state_q;
	logic            mode_q;       // color_mode register
	logic            rd_mode_q;    // mode captured for the running readout
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] rp_q;
	sample_t         min_q;
	sample_t         max_q;

	// frame memory
	pixel_t          mem_q [MaxPixels];
	pixel_t          rdata_q;

	// divider datapath
	sample_t         lo_q;
	sample_t         range_q;
	logic [NumW-1:0] rem_q;
	logic [NumW-1:0] dvs_q;
	logic [3:0]      step_q;
	pix8_t           quo_q;
	logic [1:0]      ch_q;

	// result staging and output register
	pix8_t           res_a_q, res_b_q, res_c_q;
	logic            res_last_q, res_empty_q;
	logic            out_valid_q;
	pix8_t           out_a_q, out_b_q, out_c_q;
	logic            out_last_q, out_empty_q;

	logic            in_acc, do_load, do_read;
	logic            clr_frame;
	logic [CntW-1:0] cnt_eff;
	sample_t         lo_eff, hi_eff;
	sample_t         lo1, hi1, lo2, hi2, lo3, hi3;
	logic            full;
	logic            mem_we;
	logic            is_last;
	sample_t         ch_sample;
	sample_t         diff;
	logic [NumW-1:0] num;
	logic            ge;
	pix8_t           quo_next;
	logic            ch_done;
	pix8_t           ch_result;
	logic [1:0]      ch_last;
	logic            out_load;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign do_load   = in_acc && (func == FUNC_LOAD);
	assign do_read   = in_acc && (func == FUNC_READ);

	// a load after readout began starts a fresh frame
	assign clr_frame = (rp_q != '0);
	assign cnt_eff   = clr_frame ? '0 : count_q;
	assign lo_eff    = clr_frame ? '1 : min_q;
	assign hi_eff    = clr_frame ? '0 : max_q;
	assign full      = (cnt_eff >= CntW'(MaxPixels));
	assign mem_we    = do_load && !full;

	// extremes: sample_a always, b and c only in RGB mode
	always_comb begin
		lo1 = (sample_a < lo_eff) ? sample_a : lo_eff;
		hi1 = (sample_a > hi_eff) ? sample_a : hi_eff;
		lo2 = lo1;
		hi2 = hi1;
		lo3 = lo1;
		hi3 = hi1;
		if (mode_q) begin
			lo2 = (sample_b < lo1) ? sample_b : lo1;
			hi2 = (sample_b > hi1) ? sample_b : hi1;
			lo3 = (sample_c < lo2) ? sample_c : lo2;
			hi3 = (sample_c > hi2) ? sample_c : hi2;
		end
	end

	assign is_last = ((rp_q + CntW'(1)) >= count_q);

	// channel operand and dividend (s - lo) * 255, zero when s <= lo
	always_comb begin
		case (ch_q)
			CH_A:    ch_sample = rdata_q.a;
			CH_B:    ch_sample = rdata_q.b;
			CH_C:    ch_sample = rdata_q.c;
			default: ch_sample = rdata_q.a;
		endcase
	end
	assign diff = (ch_sample > lo_q) ? (ch_sample - lo_q) : '0;
	assign num  = {diff, OutW'(0)} - NumW'(diff);

	// shared restoring divider step; top step only checks for saturation
	assign ge       = (rem_q >= dvs_q);
	assign quo_next = {quo_q[OutW-2:0], ge};
	assign ch_done  = (state_q == ST_DIV) && ((step_q == '0) || ((step_q == StepTop) && ge));
	assign ch_result = (step_q == StepTop) ? '1 : quo_next;
	assign ch_last  = rd_mode_q ? CH_C : CH_A;

	assign out_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= 1'b0;
			count_q     <= '0;
			rp_q        <= '0;
			min_q       <= '1;
			max_q       <= '0;
			out_valid_q <= 1'b0;
			ch_q        <= CH_A;
			step_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (do_load) begin
						// a fresh frame is never full; count and extremes
						// restart through cnt_eff, lo_eff and hi_eff
						if (clr_frame) begin
							rp_q <= '0;
						end
						if (!full) begin
							count_q <= cnt_eff + CntW'(1);
							min_q   <= lo3;
							max_q   <= hi3;
						end
					end else if (do_read) begin
						if (count_q == '0) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_RD;
							ch_q    <= CH_A;
							if (is_last) begin
								count_q <= '0;
								rp_q    <= '0;
								min_q   <= '1;
								max_q   <= '0;
							end else begin
								rp_q <= rp_q + CntW'(1);
							end
						end
					end
				end
				ST_RD: begin
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= ST_DIV;
					step_q  <= StepTop;
				end
				ST_DIV: begin
					if (ch_done) begin
						if (ch_q == ch_last) begin
							state_q <= ST_FIN;
						end else begin
							ch_q    <= ch_q + 2'd1;
							state_q <= ST_PREP;
						end
					end else begin
						step_q <= step_q - 4'd1;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// frame memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[cnt_eff[AddrW-1:0]] <= pixel_t'({sample_c, sample_b, sample_a});
		end
		if (do_read) begin
			rdata_q <= mem_q[rp_q[AddrW-1:0]];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (do_read) begin
			lo_q        <= min_q;
			range_q     <= (max_q > min_q) ? (max_q - min_q) : SampleW'(1);
			rd_mode_q   <= mode_q;
			res_a_q     <= '0;
			res_b_q     <= '0;
			res_c_q     <= '0;
			res_empty_q <= (count_q == '0);
			res_last_q  <= (count_q != '0) && is_last;
		end
		if (state_q == ST_PREP) begin
			rem_q <= num;
			dvs_q <= {range_q, OutW'(0)};
			quo_q <= '0;
		end
		if (state_q == ST_DIV) begin
			if (ge && (step_q != StepTop)) begin
				rem_q <= rem_q - dvs_q;
			end
			if (step_q != StepTop) begin
				quo_q <= quo_next;
			end
			dvs_q <= dvs_q >> 1;
			if (ch_done) begin
				case (ch_q)
					CH_A:    res_a_q <= ch_result;
					CH_B:    res_b_q <= ch_result;
					CH_C:    res_c_q <= ch_result;
					default: res_a_q <= ch_result;
				endcase
			end
		end
		if (out_load) begin
			out_a_q     <= res_a_q;
			out_b_q     <= res_b_q;
			out_c_q     <= res_c_q;
			out_last_q  <= res_last_q;
			out_empty_q <= res_empty_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_a       = out_a_q;
	assign out_b       = out_b_q;
	assign out_c       = out_c_q;
	assign last_pixel  = out_last_q;
	assign frame_empty = out_empty_q;

	`MCS_ASSERT_ALWAYS(a_count_max, count_q <= CntW'(MaxPixels), "pixel count past capacity")
	`MCS_ASSERT_ALWAYS(a_rp_bound, (rp_q == '0) || (rp_q < count_q),
		"read pointer beyond stored pixels")
	`MCS_ASSERT_IMPL(a_empty_zero, out_valid_q && out_empty_q,
		(out_a_q == '0) && (out_b_q == '0) && (out_c_q == '0) && !out_last_q,
		"empty readout carries data")
	`MCS_ASSERT_IMPL(a_grey_zero, (state_q == ST_FIN) && !rd_mode_q && !res_empty_q,
		(res_b_q == '0) && (res_c_q == '0), "grey readout with nonzero b or c")

endmodule

`default_nettype wire
